// ===== src/xy_line_to_quad_expander_defines.svh =====
// Assertion macros for the expander, the file that checks itself.
`ifndef XY_LINE_TO_QUAD_EXPANDER_DEFINES_SVH
`define XY_LINE_TO_QUAD_EXPANDER_DEFINES_SVH

// Assert that a condition implies a consequence on the same edge.
`define XLQ_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence on the next edge.
`define XLQ_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/xlq_pkg.sv =====
package xlq_pkg;

  localparam int SampleBits = 16;
  localparam int HwBits = 15;
  localparam logic [HwBits-1:0] HwReset = 15'd655;
  // Sum of squares gets 2*(SampleBits+1)+2 bits; the root half of that.
  localparam int SumBits = 2 * (SampleBits + 1) + 2;
  localparam int RootBits = SumBits / 2;
  // Product |d|*w and the rounded quotient.
  localparam int ProdBits = SampleBits + 1 + HwBits + 1;
  localparam int QuoBits = HwBits + 1;
  localparam int VertexCount = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DIVX,
    ST_DIVY,
    ST_EMIT
  } state_t;

  // Control toward the serial arithmetic unit.
  typedef struct packed {
    logic start_root;
    logic start_div;
  } unit_ctrl_t;

  // Status from the serial arithmetic unit.
  typedef struct packed {
    logic done;
  } unit_stat_t;

  function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
    if (v > 20'sd131071) begin
      return 18'sd131071;
    end else if (v < -20'sd131072) begin
      return -18'sd131072;
    end
    return v[17:0];
  endfunction

endpackage

// ===== src/xlq_root.sv =====
// Bit-serial square root: one result bit per cycle (restoring method).
module xlq_root (
  input  logic                          clk,
  input  logic                          start,
  input  logic [xlq_pkg::SumBits-1:0]   radicand,
  output logic                          done,
  output logic [xlq_pkg::RootBits-1:0]  root
);
  import xlq_pkg::*;

  localparam int CntBits = $clog2(RootBits + 1);

  logic [SumBits-1:0]  rad;
  logic [RootBits+1:0] rem;
  logic [CntBits-1:0]  cnt;
  logic                busy;
  logic [RootBits+1:0] trial;
  logic [RootBits+1:0] shifted;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    shifted = {rem[RootBits-1:0], rad[SumBits-1 -: 2]};
    trial   = shifted - {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CntBits'(RootBits);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rad <= {rad[SumBits-3:0], 2'b00};
      if (!trial[RootBits+1]) begin
        rem  <= trial;
        root <= {root[RootBits-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        root <= {root[RootBits-2:0], 1'b0};
      end
      cnt  <= cnt - 1'b1;
      done <= (cnt == CntBits'(1));
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule

// ===== src/xlq_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module xlq_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic [xlq_pkg::ProdBits-1:0]  dividend,
  input  logic [xlq_pkg::RootBits-1:0]  divisor,
  output logic                          done,
  output logic [xlq_pkg::ProdBits-1:0]  quotient
);
  import xlq_pkg::*;

  localparam int CntBits = $clog2(ProdBits + 1);

  logic [ProdBits-1:0] num;
  logic [RootBits:0]   rem;
  logic [RootBits:0]   shifted;
  logic [RootBits:0]   diff;
  logic [CntBits-1:0]  cnt;
  logic                busy;

  always_comb begin
    shifted = {rem[RootBits-1:0], num[ProdBits-1]};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      rem      <= '0;
      quotient <= '0;
      cnt      <= CntBits'(ProdBits);
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      num <= {num[ProdBits-2:0], 1'b0};
      if (!diff[RootBits]) begin
        rem      <= diff;
        quotient <= {quotient[ProdBits-2:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[ProdBits-2:0], 1'b0};
      end
      cnt  <= cnt - 1'b1;
      done <= (cnt == CntBits'(1));
      if (cnt == CntBits'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule

// ===== src/xy_line_to_quad_expander.sv =====
// XY line to quad expander.
// Input channel: sample_x, sample_y, brightness with in_valid / in_stall.
// A transfer happens on a rising edge with valid high and stall low.
// Output channel: one vertex per transfer on out_valid / out_stall; each
// input sample yields six vertices, the sixth flagged by last_vertex.
// half_width is written through cfg_write / cfg_data; the user must write
// it only while idle, as the block itself does not enforce that.
// Processing: serial squaring, a bit-serial square root and two passes
// (serial multiply by the width, then bit-serial divide), then the six
// vertices are emitted; a new sample is accepted the cycle after the sixth
// has transferred. A zero-length segment skips both passes.
// Reset (rst, synchronous) sets half_width to 655 and the kept point to
// the origin. While the receiver stalls the current vertex holds and no
// new sample is taken until all six have been transferred.
module xy_line_to_quad_expander (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_x,
  input  logic signed [15:0] sample_y,
  input  logic [15:0]        brightness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] vertex_x,
  output logic signed [17:0] vertex_y,
  output logic [15:0]        vertex_bright,
  output logic signed [17:0] along_coord,
  output logic signed [15:0] across_coord,
  output logic [16:0]        segment_length,
  output logic               last_vertex
);
  import xlq_pkg::*;
  `include "xy_line_to_quad_expander_defines.svh"

  localparam int SqCntBits = $clog2(SampleBits + 2);

  state_t state, state_next;
  logic [HwBits-1:0] hw;
  logic signed [SampleBits-1:0] x0, y0, x1, y1;
  logic [15:0] bright;
  logic signed [SampleBits:0] dx, dy;
  logic [SampleBits:0] mag_a, mag_b;
  logic [SumBits-1:0] sum;
  logic [SampleBits:0] mplier;
  logic [SampleBits:0] mcand;
  logic [SqCntBits-1:0] sq_cnt;
  logic sq_second;
  logic [RootBits-1:0] z;
  logic signed [QuoBits:0] ddx, ddy;
  logic [2:0] vcnt;
  unit_ctrl_t ctrl;
  unit_stat_t root_stat, div_stat;
  logic [RootBits-1:0] root_val;
  logic [ProdBits-1:0] quo;
  logic [ProdBits-1:0] div_num;
  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign dx = (SampleBits+1)'(x1) - (SampleBits+1)'(x0);
  assign dy = (SampleBits+1)'(y1) - (SampleBits+1)'(y0);

  // Magnitudes of the deltas.
  always_comb begin
    mag_a = dx[SampleBits] ? (SampleBits+1)'(-dx) : dx;
    mag_b = dy[SampleBits] ? (SampleBits+1)'(-dy) : dy;
  end

  // Rounded dividend |delta|*w + z/2 for the current axis; the product is
  // formed serially through the squaring shift-add as well.
  logic [ProdBits-1:0] prod;
  assign div_num = prod + ProdBits'(z >> 1);

  xlq_root u_root (
    .clk(clk), .start(ctrl.start_root), .radicand(sum),
    .done(root_stat.done), .root(root_val)
  );

  xlq_div u_div (
    .clk(clk), .start(ctrl.start_div), .dividend(div_num), .divisor(z),
    .done(div_stat.done), .quotient(quo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_SQUARE;
      ST_SQUARE: if (sq_second && sq_cnt == '0) state_next = ST_ROOT;
      ST_ROOT:   if (root_stat.done) state_next = ST_DIVX;
      ST_DIVX:   if (z == '0 || (div_stat.done && sq_second)) state_next = ST_DIVY;
      ST_DIVY:   if (z == '0 || (div_stat.done && sq_second)) state_next = ST_EMIT;
      ST_EMIT:   if (out_xfer && vcnt == 3'(VertexCount - 1)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
  end

  // Control: serial multiply (shift-add), one multiplier bit per cycle.
  // sq_second marks the second pass of squaring, or in divide states
  // that the product is ready and the divider has been started.
  logic div_started;

  // Start pulses for the root and the divider, registered: each is raised in
  // the cycle after its operand is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl.start_root <= (state == ST_SQUARE) && sq_second && (sq_cnt == '0);
      ctrl.start_div  <= (state == ST_DIVX || state == ST_DIVY) && (z != '0) &&
                         !div_started && (sq_cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hw    <= HwReset;
      x0    <= '0;
      y0    <= '0;
      vcnt  <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) hw <= cfg_data;
      unique case (state)
        ST_IDLE: if (in_xfer) begin
          x1 <= sample_x; y1 <= sample_y; bright <= brightness;
          sum <= '0; sq_second <= 1'b0; sq_cnt <= SqCntBits'(SampleBits + 1);
        end
        ST_SQUARE: begin
          if (sq_cnt == SqCntBits'(SampleBits + 1)) begin
            mplier <= sq_second ? mag_b : mag_a;
            mcand  <= sq_second ? mag_b : mag_a;
            prod   <= '0;
            sq_cnt <= sq_cnt - 1'b1;
          end else if (sq_cnt != '0) begin
            if (mplier[0]) sum <= sum + (SumBits'(mcand) << (SampleBits - sq_cnt));
            mplier <= mplier >> 1;
            sq_cnt <= sq_cnt - 1'b1;
          end else if (!sq_second) begin
            sq_second <= 1'b1;
            sq_cnt <= SqCntBits'(SampleBits + 1);
          end
        end
        ST_ROOT: if (root_stat.done) begin
          z <= root_val;
          sq_second <= 1'b0; div_started <= 1'b0;
          sq_cnt <= SqCntBits'(SampleBits + 1);
          mplier <= mag_a; prod <= '0;
          if (root_val == '0) begin
            ddx <= (QuoBits+1)'(hw); ddy <= '0;
          end
        end
        ST_DIVX, ST_DIVY: if (z != '0) begin
          // Serial product |delta| * w, then one divide.
          if (!div_started) begin
            if (sq_cnt != '0) begin
              if (mplier[0]) prod <= prod + (ProdBits'(hw) << (SampleBits + 1 - sq_cnt));
              mplier <= mplier >> 1;
              sq_cnt <= sq_cnt - 1'b1;
            end else begin
              div_started <= 1'b1;
              sq_second <= 1'b1;
            end
          end else if (div_stat.done) begin
            if (state == ST_DIVX) begin
              ddx <= dx[SampleBits] ? -(QuoBits+1)'(quo) : (QuoBits+1)'(quo);
            end else begin
              ddy <= dy[SampleBits] ? -(QuoBits+1)'(quo) : (QuoBits+1)'(quo);
            end
            div_started <= 1'b0; sq_second <= 1'b0;
            sq_cnt <= SqCntBits'(SampleBits + 1);
            mplier <= mag_b; prod <= '0;
          end
        end
        ST_EMIT: if (out_xfer) begin
          vcnt <= (vcnt == 3'(VertexCount - 1)) ? '0 : vcnt + 1'b1;
          if (vcnt == 3'(VertexCount - 1)) begin
            x0 <= x1; y0 <= y1;
          end
        end
        default: ;
      endcase
    end
  end

  // Vertex formation: p0 vertices are 0,1,3; +n vertices are 1,3,5.
  logic at_p1, plus_n;
  logic signed [19:0] bx, by, ex, ey;
  always_comb begin
    at_p1  = (vcnt == 3'd2) || (vcnt == 3'd4) || (vcnt == 3'd5);
    plus_n = (vcnt == 3'd1) || (vcnt == 3'd3) || (vcnt == 3'd5);
    bx = at_p1 ? 20'(x1) + 20'(ddx) : 20'(x0) - 20'(ddx);
    by = at_p1 ? 20'(y1) + 20'(ddy) : 20'(y0) - 20'(ddy);
    // n = (-ddy, ddx).
    ex = plus_n ? bx - 20'(ddy) : bx + 20'(ddy);
    ey = plus_n ? by + 20'(ddx) : by - 20'(ddx);
    vertex_x = sat18(ex);
    vertex_y = sat18(ey);
    vertex_bright = bright;
    along_coord = at_p1 ? sat18(20'($signed({1'b0, z})) + 20'(hw)) : -18'(hw);
    across_coord = plus_n ? 16'(hw) : -16'(hw);
    segment_length = (z > RootBits'(131071)) ? 17'd131071 : 17'(z);
    last_vertex = (vcnt == 3'(VertexCount - 1));
  end

  `XLQ_ASSERT_IMP(a_no_out_idle, clk, rst, state == ST_IDLE, !out_valid, "vertex outside emit")
  `XLQ_ASSERT_NEXT(a_last_ends, clk, rst, out_xfer && last_vertex, state == ST_IDLE,
    "segment did not end after last vertex")
  `XLQ_ASSERT_IMP(a_stall_busy, clk, rst, state != ST_IDLE, in_stall, "input taken while busy")
endmodule
